### sv/pcda_pkg.sv
// Package with the constants, codes and entry types of the per-class detection aggregator.
package pcda_pkg;

    localparam int NUM_CLASSES = 64;
    localparam int CLASS_W     = 6;
    localparam int COUNT_BINS  = 16;
    localparam int BIN_W       = 4;
    localparam int MAX_FRAMES  = 256;
    localparam int FRAMES_W    = 9;
    localparam int HIST_W      = 9;
    localparam int HIST_AW     = CLASS_W + BIN_W;
    localparam int HIST_DEPTH  = NUM_CLASSES * COUNT_BINS;
    localparam int SUM_W       = HIST_W + BIN_W;
    localparam int NUM_W       = 18;

    // Input commands.
    localparam logic [1:0] CMD_BOX    = 2'd0;
    localparam logic [1:0] CMD_FRAME  = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // Aggregation modes.
    localparam logic [1:0] MODE_AVG   = 2'd0;
    localparam logic [1:0] MODE_VOTE  = 2'd1;
    localparam logic [1:0] MODE_TOTAL = 2'd2;

    // Register indexes.
    localparam logic REG_MODE = 1'b0;

    // One per-class entry of the class memory.
    typedef struct packed {
        logic        seen;
        logic        in_frame;
        logic [7:0]  frame_cnt;
        logic [15:0] total;
    } cls_entry_t;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_BOX   = 6'b000100,
        ST_CLOSE = 6'b001000,
        ST_FIN   = 6'b010000,
        ST_LAST  = 6'b100000
    } state_t;

endpackage

### sv/per_class_detection_aggregator.sv
// Top level of the per-class detection aggregator: class and histogram memories and sequencer.
//
// The block accepts one request at a time. After reset a clearing pass sweeps the histogram
// memory, one entry per cycle, and also clears the class memory before the first request is
// taken. A box is one read-modify-write of the class memory. A frame end walks the class
// memory one class per cycle, and each class present in the frame bumps one histogram bin
// through a second read-modify-write stage. A finish walks all 64 classes, each with one
// class read and 15 histogram bin reads, and may stall on the result stream; one result per
// seen class is sent in ascending class order, or a single empty result when no class was
// seen. Boxes and frame ends past the frame capacity of 256 only set the overflow flag.
module per_class_detection_aggregator
    import pcda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [5:0] class_id, [7:6] zero
    input  logic [1:0]  s_tuser,   // [1:0] command
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] result_class, [13:6] value, [15:14] zero
    output logic [1:0]  m_tuser,   // [0] any_found, [1] frames_dropped
    output logic        m_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Memories.
    cls_entry_t         cls_mem [NUM_CLASSES];
    logic [HIST_W-1:0]  hist_mem [HIST_DEPTH];

    cls_entry_t         cls_rdata;
    logic [HIST_W-1:0]  hist_rdata;
    logic               cls_we;
    logic [CLASS_W-1:0] cls_raddr;
    logic [CLASS_W-1:0] cls_waddr;
    cls_entry_t         cls_wdata;
    logic               hist_re;
    logic               hist_we;
    logic [HIST_AW-1:0] hist_raddr;
    logic [HIST_AW-1:0] hist_waddr;
    logic [HIST_W-1:0]  hist_wdata;

    // Control and data registers.
    state_t               state_reg;
    logic [1:0]           mode_reg;
    logic [FRAMES_W-1:0]  frames_done_reg;
    logic                 frame_open_reg;
    logic                 overflow_reg;
    logic                 pend_fin_reg;
    logic [HIST_AW-1:0]   clr_cnt_reg;
    logic [CLASS_W-1:0]   box_cls_reg;
    logic [CLASS_W:0]     walk_cnt_reg;
    logic                 p1_valid_reg;
    logic [CLASS_W-1:0]   p1_cls_reg;
    logic                 p2_valid_reg;
    logic [HIST_AW-1:0]   p2_addr_reg;
    logic [CLASS_W-1:0]   fin_cls_reg;
    logic [4:0]           step_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [HIST_W-1:0]    max_reg;
    logic [BIN_W-1:0]     maxbin_reg;
    logic                 seen_reg;
    logic [15:0]          total_reg;
    logic [NUM_W-1:0]     rem_reg;
    logic [7:0]           quot_reg;
    logic                 dsat_reg;
    logic                 held_valid_reg;
    logic [CLASS_W-1:0]   held_cls_reg;
    logic [7:0]           held_val_reg;
    logic                 m_valid_reg;
    logic [CLASS_W-1:0]   out_cls_reg;
    logic [7:0]           out_val_reg;
    logic                 out_any_reg;
    logic                 out_drop_reg;
    logic                 out_last_reg;

    logic                 in_accept;
    logic                 out_free;
    logic                 out_load;
    logic                 at_capacity;
    logic [BIN_W-1:0]     p1_bin;
    logic [NUM_W-1:0]     div_num;
    logic [NUM_W-1:0]     div_top;
    logic [NUM_W-1:0]     div_trial;
    logic [2:0]           div_shift;
    logic [SUM_W-1:0]     bin0;
    logic [7:0]           class_val;

    assign s_tready    = (state_reg == ST_IDLE);
    assign in_accept   = s_tvalid && s_tready;
    assign out_free    = !m_valid_reg || m_tready;
    assign at_capacity = (frames_done_reg >= FRAMES_W'(MAX_FRAMES));

    // A new result enters the output register in this cycle.
    assign out_load = ((state_reg == ST_FIN) && (step_reg > 5'd15) && seen_reg
                       && held_valid_reg && out_free)
                      || ((state_reg == ST_LAST) && out_free);

    // Held bin of the class in the close walk.
    assign p1_bin = (cls_rdata.frame_cnt > 8'(COUNT_BINS - 1)) ? BIN_W'(COUNT_BINS - 1)
                                                               : cls_rdata.frame_cnt[BIN_W-1:0];

    // Divider operands for the rounded average.
    assign div_num   = {1'b0, cls_rdata.total, 1'b0} + NUM_W'(frames_done_reg);
    assign div_top   = {frames_done_reg, 1'b0, 8'b0};
    assign div_shift = 3'(4'd9 - step_reg[3:0]);
    assign div_trial = NUM_W'({frames_done_reg, 1'b0}) << div_shift;

    // Frames without the class, and the value of the class under the current mode.
    assign bin0 = (SUM_W'(frames_done_reg) >= sum_reg) ? SUM_W'(frames_done_reg) - sum_reg
                                                        : '0;
    always_comb
    begin
        case (mode_reg)
            MODE_AVG:
            begin
                if (frames_done_reg == '0)
                    class_val = 8'd0;
                else if (dsat_reg)
                    class_val = 8'd255;
                else
                    class_val = quot_reg;
            end
            MODE_VOTE:
            begin
                class_val = (SUM_W'(max_reg) >= bin0) ? 8'(maxbin_reg) : 8'd0;
            end
            default:
            begin
                class_val = (total_reg > 16'd255) ? 8'd255 : total_reg[7:0];
            end
        endcase
    end

    // Memory port selection.
    always_comb
    begin
        cls_raddr  = s_tdata[CLASS_W-1:0];
        cls_we     = 1'b0;
        cls_waddr  = box_cls_reg;
        cls_wdata  = cls_rdata;
        hist_re    = 1'b0;
        hist_raddr = {fin_cls_reg, BIN_W'(1)};
        hist_we    = 1'b0;
        hist_waddr = p2_addr_reg;
        hist_wdata = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cls_we     = 1'b1;
                cls_waddr  = clr_cnt_reg[CLASS_W-1:0];
                cls_wdata  = '0;
                hist_we    = 1'b1;
                hist_waddr = clr_cnt_reg;
            end
            ST_BOX:
            begin
                cls_we             = 1'b1;
                cls_wdata.seen     = 1'b1;
                cls_wdata.in_frame = 1'b1;
                if (cls_rdata.frame_cnt != 8'hff)
                    cls_wdata.frame_cnt = cls_rdata.frame_cnt + 8'd1;
                if (cls_rdata.total != 16'hffff)
                    cls_wdata.total = cls_rdata.total + 16'd1;
            end
            ST_CLOSE:
            begin
                cls_raddr = walk_cnt_reg[CLASS_W-1:0];
                if (p1_valid_reg)
                begin
                    cls_we              = 1'b1;
                    cls_waddr           = p1_cls_reg;
                    cls_wdata.in_frame  = 1'b0;
                    cls_wdata.frame_cnt = '0;
                    hist_re    = cls_rdata.in_frame && (p1_bin != '0);
                    hist_raddr = {p1_cls_reg, p1_bin};
                end
                if (p2_valid_reg)
                begin
                    hist_we    = 1'b1;
                    hist_waddr = p2_addr_reg;
                    hist_wdata = hist_rdata + HIST_W'(1);
                end
            end
            ST_FIN:
            begin
                cls_raddr = fin_cls_reg;
                if (step_reg == 5'd0)
                begin
                    hist_re    = 1'b1;
                    hist_raddr = {fin_cls_reg, BIN_W'(1)};
                end
                else if (step_reg <= 5'd15)
                begin
                    hist_we    = 1'b1;
                    hist_waddr = {fin_cls_reg, step_reg[BIN_W-1:0]};
                    hist_re    = (step_reg < 5'd15);
                    hist_raddr = {fin_cls_reg, step_reg[BIN_W-1:0] + BIN_W'(1)};
                    if (step_reg == 5'd1)
                    begin
                        cls_we    = 1'b1;
                        cls_waddr = fin_cls_reg;
                        cls_wdata = '0;
                    end
                end
            end
            default:
            begin
                cls_raddr = s_tdata[CLASS_W-1:0];
            end
        endcase
    end

    // Class memory.
    always_ff @(posedge clk)
    begin
        if (cls_we)
            cls_mem[cls_waddr] <= cls_wdata;
        cls_rdata <= cls_mem[cls_raddr];
    end

    // Histogram memory.
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_waddr] <= hist_wdata;
        if (hist_re)
            hist_rdata <= hist_mem[hist_raddr];
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_VOTE;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_MODE))
            mode_reg <= pwdata[1:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODE) ? {30'b0, mode_reg} : 32'b0;

    // Sequencer and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            frames_done_reg <= '0;
            frame_open_reg  <= 1'b0;
            overflow_reg    <= 1'b0;
            pend_fin_reg    <= 1'b0;
            clr_cnt_reg     <= '0;
            walk_cnt_reg    <= '0;
            p1_valid_reg    <= 1'b0;
            p2_valid_reg    <= 1'b0;
            fin_cls_reg     <= '0;
            step_reg        <= '0;
            held_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_tready && !out_load)
                m_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + HIST_AW'(1);
                    if (clr_cnt_reg == HIST_AW'(HIST_DEPTH - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        box_cls_reg  <= s_tdata[CLASS_W-1:0];
                        walk_cnt_reg <= '0;
                        fin_cls_reg  <= '0;
                        step_reg     <= '0;
                        case (s_tuser)
                            CMD_BOX:
                            begin
                                if (at_capacity)
                                    overflow_reg <= 1'b1;
                                else
                                    state_reg <= ST_BOX;
                            end
                            CMD_FRAME:
                            begin
                                frame_open_reg <= 1'b0;
                                if (at_capacity)
                                    overflow_reg <= 1'b1;
                                else
                                begin
                                    pend_fin_reg <= 1'b0;
                                    state_reg    <= ST_CLOSE;
                                end
                            end
                            CMD_FINISH:
                            begin
                                if (frame_open_reg)
                                begin
                                    pend_fin_reg <= 1'b1;
                                    state_reg    <= ST_CLOSE;
                                end
                                else
                                    state_reg <= ST_FIN;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_BOX:
                begin
                    frame_open_reg <= 1'b1;
                    state_reg      <= ST_IDLE;
                end
                ST_CLOSE:
                begin
                    // Issue stage, bin lookup stage and histogram update stage.
                    p1_valid_reg <= (walk_cnt_reg < (CLASS_W + 1)'(NUM_CLASSES));
                    p1_cls_reg   <= walk_cnt_reg[CLASS_W-1:0];
                    if (walk_cnt_reg < (CLASS_W + 1)'(NUM_CLASSES))
                        walk_cnt_reg <= walk_cnt_reg + (CLASS_W + 1)'(1);
                    p2_valid_reg <= p1_valid_reg && cls_rdata.in_frame && (p1_bin != '0);
                    p2_addr_reg  <= {p1_cls_reg, p1_bin};
                    if ((walk_cnt_reg == (CLASS_W + 1)'(NUM_CLASSES)) && !p1_valid_reg
                        && !p2_valid_reg)
                    begin
                        frames_done_reg <= frames_done_reg + FRAMES_W'(1);
                        frame_open_reg  <= 1'b0;
                        state_reg       <= pend_fin_reg ? ST_FIN : ST_IDLE;
                        pend_fin_reg    <= 1'b0;
                        fin_cls_reg     <= '0;
                        step_reg        <= '0;
                    end
                end
                ST_FIN:
                begin
                    if (step_reg == 5'd0)
                    begin
                        sum_reg    <= '0;
                        max_reg    <= '0;
                        maxbin_reg <= '0;
                        step_reg   <= 5'd1;
                    end
                    else if (step_reg <= 5'd15)
                    begin
                        // Bin scan: running sum and last bin holding the largest count.
                        sum_reg <= sum_reg + SUM_W'(hist_rdata);
                        if (hist_rdata >= max_reg)
                        begin
                            max_reg    <= hist_rdata;
                            maxbin_reg <= step_reg[BIN_W-1:0];
                        end
                        // Rounded average by restoring division, one quotient bit a step.
                        if (step_reg == 5'd1)
                        begin
                            seen_reg  <= cls_rdata.seen;
                            total_reg <= cls_rdata.total;
                            rem_reg   <= div_num;
                            dsat_reg  <= (div_num >= div_top);
                            quot_reg  <= '0;
                        end
                        else if (step_reg <= 5'd9)
                        begin
                            if (rem_reg >= div_trial)
                            begin
                                rem_reg              <= rem_reg - div_trial;
                                quot_reg[div_shift]  <= 1'b1;
                            end
                        end
                        step_reg <= step_reg + 5'd1;
                    end
                    else
                    begin
                        // Result of this class: the previous one is sent once the port frees.
                        if (!seen_reg || !held_valid_reg || out_free)
                        begin
                            if (seen_reg)
                            begin
                                if (held_valid_reg)
                                begin
                                    m_valid_reg  <= 1'b1;
                                    out_cls_reg  <= held_cls_reg;
                                    out_val_reg  <= held_val_reg;
                                    out_any_reg  <= 1'b1;
                                    out_drop_reg <= overflow_reg;
                                    out_last_reg <= 1'b0;
                                end
                                held_valid_reg <= 1'b1;
                                held_cls_reg   <= fin_cls_reg;
                                held_val_reg   <= class_val;
                            end
                            step_reg <= '0;
                            if (fin_cls_reg == CLASS_W'(NUM_CLASSES - 1))
                                state_reg <= ST_LAST;
                            else
                                fin_cls_reg <= fin_cls_reg + CLASS_W'(1);
                        end
                    end
                end
                ST_LAST:
                begin
                    // Final result, or the empty result when no class was seen.
                    if (out_free)
                    begin
                        m_valid_reg     <= 1'b1;
                        out_cls_reg     <= held_valid_reg ? held_cls_reg : '0;
                        out_val_reg     <= held_valid_reg ? held_val_reg : '0;
                        out_any_reg     <= held_valid_reg;
                        out_drop_reg    <= overflow_reg;
                        out_last_reg    <= 1'b1;
                        held_valid_reg  <= 1'b0;
                        frames_done_reg <= '0;
                        frame_open_reg  <= 1'b0;
                        overflow_reg    <= 1'b0;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result stream.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b0, out_val_reg, out_cls_reg};
    assign m_tuser  = {out_drop_reg, out_any_reg};
    assign m_tlast  = out_last_reg;

    // The frame count never passes the capacity.
    a_frames_cap: assert property (@(posedge clk) disable iff (!rst_n)
        frames_done_reg <= FRAMES_W'(MAX_FRAMES))
        else $error("frame count above capacity");

    // Read and write of the histogram never meet at one entry in a cycle.
    a_hist_hazard: assert property (@(posedge clk) disable iff (!rst_n)
        (hist_re && hist_we) |-> (hist_raddr != hist_waddr))
        else $error("histogram read and write at one entry");

    // The final result of a finish leaves the block cleared and idle.
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LAST && out_free) |=>
            (state_reg == ST_IDLE && frames_done_reg == '0 && !overflow_reg && m_tlast))
        else $error("finish did not clear state");

    // No request is taken during the clearing pass.
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("request accepted during clearing pass");

endmodule

### tb/tb_per_class_detection_aggregator.sv
// Self-checking testbench for the per-class detection aggregator with random stream idling.
module tb_per_class_detection_aggregator;
    import pcda_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 100;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One aggregate result as it leaves the block.
    typedef struct {
        logic [5:0] cls;
        logic [7:0] value;
        logic       any_found;
        logic       dropped;
        logic       last;
    } agg_result_t;

    // Scoreboard: tracks the per-class counts and predicts finish results.
    class aggregate_scoreboard;
        logic [1:0]  mode;
        int unsigned frame_cnt[NUM_CLASSES];
        int unsigned total_cnt[NUM_CLASSES];
        bit          seen[NUM_CLASSES];
        bit          in_frame[NUM_CLASSES];
        int unsigned hist[NUM_CLASSES][COUNT_BINS];
        int unsigned frames;
        bit          open;
        bit          overflow;
        agg_result_t pending[$];

        function new();
            mode = MODE_VOTE;
            clear_all();
        endfunction

        function void clear_frame();
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                frame_cnt[c] = 0;
                in_frame[c] = 0;
            end
            open = 0;
        endfunction

        function void clear_all();
            clear_frame();
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                total_cnt[c] = 0;
                seen[c] = 0;
                for (int b = 0; b < COUNT_BINS; b++)
                    hist[c][b] = 0;
            end
            frames = 0;
            overflow = 0;
        endfunction

        // Append one expected result at the tail of the queue.
        function void queue_expected(agg_result_t r);
            pending.insert(pending.size(), r);
        endfunction

        // Close the open frame: bump each present class's held per-frame bin, or set overflow.
        function void close_frame();
            int unsigned k;
            if (frames >= MAX_FRAMES)
                overflow = 1;
            else
            begin
                for (int c = 0; c < NUM_CLASSES; c++)
                begin
                    if (in_frame[c])
                    begin
                        k = (frame_cnt[c] > COUNT_BINS - 1) ? COUNT_BINS - 1 : frame_cnt[c];
                        if (k > 0)
                            hist[c][k]++;
                    end
                end
                frames++;
            end
            clear_frame();
        endfunction

        function logic [7:0] class_value(int c);
            int unsigned v;
            int unsigned sum;
            int unsigned best;
            v = 0;
            if (mode == MODE_AVG)
            begin
                if (frames != 0)
                    v = (2 * total_cnt[c] + frames) / (2 * frames);
            end
            else if (mode == MODE_VOTE)
            begin
                sum = 0;
                for (int b = 1; b < COUNT_BINS; b++)
                    sum += hist[c][b];
                // Frames without the class vote for a count of zero.
                best = (frames >= sum) ? frames - sum : 0;
                for (int b = 1; b < COUNT_BINS; b++)
                begin
                    if (hist[c][b] >= best)
                    begin
                        best = hist[c][b];
                        v = b;
                    end
                end
            end
            else
                v = total_cnt[c];
            return (v > 255) ? 8'd255 : v[7:0];
        endfunction

        // Note one accepted request and queue the results it causes.
        function void note_request(logic [1:0] cmd, logic [5:0] cls);
            agg_result_t r;
            int n;
            if (cmd == CMD_BOX)
            begin
                if (frames >= MAX_FRAMES)
                    overflow = 1;
                else
                begin
                    if (frame_cnt[cls] < 255)
                        frame_cnt[cls]++;
                    if (total_cnt[cls] < 65535)
                        total_cnt[cls]++;
                    seen[cls] = 1;
                    in_frame[cls] = 1;
                    open = 1;
                end
            end
            else if (cmd == CMD_FRAME)
                close_frame();
            else if (cmd == CMD_FINISH)
            begin
                if (open)
                    close_frame();
                n = 0;
                for (int c = 0; c < NUM_CLASSES; c++)
                begin
                    if (seen[c])
                    begin
                        r.cls = c[5:0];
                        r.value = class_value(c);
                        r.any_found = 1;
                        r.dropped = overflow;
                        r.last = 0;
                        queue_expected(r);
                        n++;
                    end
                end
                if (n == 0)
                begin
                    r.cls = '0;
                    r.value = '0;
                    r.any_found = 0;
                    r.dropped = overflow;
                    r.last = 1;
                    queue_expected(r);
                end
                else
                    pending[pending.size() - 1].last = 1;
                clear_all();
            end
        endfunction

        // Compare one result with the oldest expectation; an empty string means a match.
        function string check_result(agg_result_t got);
            agg_result_t want;
            if (pending.size() == 0)
                return $sformatf("unexpected result class %0d value %0d", got.cls, got.value);
            want = pending.pop_front();
            if (got.cls !== want.cls || got.value !== want.value ||
                got.any_found !== want.any_found || got.dropped !== want.dropped ||
                got.last !== want.last)
                return $sformatf("got cls %0d val %0d any %0b drop %0b last %0b, want %0d %0d %0b %0b %0b",
                    got.cls, got.value, got.any_found, got.dropped, got.last,
                    want.cls, want.value, want.any_found, want.dropped, want.last);
            return "";
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    aggregate_scoreboard sb;
    int errors;
    int idle_cycles;
    int burst_left;
    int stall_left;
    int free_left;
    int item_count;

    per_class_detection_aggregator dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    // Clock.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // Send one request, opening a random gap before each new burst.
    task automatic send_request(logic [1:0] cmd, logic [5:0] cls);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b00, cls};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(cmd, cls);
        if (cmd != CMD_UNUSED)
            item_count++;
    endtask

    // Drop the request stream and wait until every result is in and the block is idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(logic [1:0] mode);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'd4 * REG_MODE;
        pwdata <= {30'($urandom()), mode};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.mode = mode;
        @(posedge clk);
    endtask

    // Receiver: free-running stretches alternate with random stalls.
    always @(posedge clk)
    begin
        if (free_left > 0)
        begin
            free_left--;
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
            free_left = $urandom_range(5, 40);
        else
        begin
            m_tready <= $urandom_range(0, 1);
            if ($urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 8);
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        agg_result_t got;
        string msg;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.cls = m_tdata[5:0];
            got.value = m_tdata[13:6];
            got.any_found = m_tuser[0];
            got.dropped = m_tuser[1];
            got.last = m_tlast;
            msg = sb.check_result(got);
            if (msg != "")
                report_mismatch(msg);
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        int base;
        int nframes;
        int nboxes;
        sb = new();
        errors = 0;
        idle_cycles = 0;
        burst_left = 0;
        stall_left = 0;
        free_left = 0;
        item_count = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_BOX;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Finish with nothing seen, under the reset mode.
        send_request(CMD_FINISH, 6'd0);
        // Extreme classes, an empty frame, the unused command, and a finish with an open frame.
        send_request(CMD_BOX, 6'd0);
        send_request(CMD_BOX, 6'd63);
        send_request(CMD_BOX, 6'd63);
        send_request(CMD_FRAME, 6'd0);
        send_request(CMD_FRAME, 6'd42);
        send_request(CMD_UNUSED, 6'd21);
        send_request(CMD_BOX, 6'd63);
        send_request(CMD_FINISH, 6'd0);
        drain();

        // Every mode, including the spare code, on the same pattern.
        for (int m = 0; m < 4; m++)
        begin
            write_mode(m[1:0]);
            send_request(CMD_BOX, 6'd1);
            send_request(CMD_BOX, 6'd1);
            send_request(CMD_BOX, 6'd2);
            send_request(CMD_FRAME, 6'd0);
            send_request(CMD_BOX, 6'd1);
            send_request(CMD_FRAME, 6'd0);
            send_request(CMD_FRAME, 6'd0);
            send_request(CMD_FINISH, 6'd0);
            drain();
        end

        // Saturation: per-frame count held in the vote.
        write_mode(MODE_VOTE);
        repeat (20) send_request(CMD_BOX, 6'd5);
        send_request(CMD_FINISH, 6'd0);
        drain();

        // Random phases of well-formed frames with some noise and broken endings.
        while (item_count < 160)
        begin
            write_mode(2'($urandom_range(0, 3)));
            base = $urandom_range(0, 60);
            nframes = $urandom_range(1, 5);
            for (int f = 0; f < nframes; f++)
            begin
                nboxes = $urandom_range(0, 6);
                for (int b = 0; b < nboxes; b++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_request(CMD_UNUSED, 6'($urandom_range(0, 63)));
                    if ($urandom_range(0, 4) == 0)
                        send_request(CMD_BOX, 6'($urandom_range(0, 63)));
                    else
                        send_request(CMD_BOX, 6'(base + $urandom_range(0, 3)));
                end
                // Sometimes the last frame is left open for the finish to close.
                if (f != nframes - 1 || $urandom_range(0, 2) != 0)
                    send_request(CMD_FRAME, 6'($urandom_range(0, 63)));
            end
            send_request(CMD_FINISH, 6'($urandom_range(0, 63)));
            drain();
        end

        drain();
        if (errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### per_class_detection_aggregator.f
sv/pcda_pkg.sv
sv/per_class_detection_aggregator.sv
tb/tb_per_class_detection_aggregator.sv
